// ----- rtl/lru_page_replacement_macros.svh -----
// Assertion macros used by the LRU page replacement checker.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lrupr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lrupr: next-cycle check failed");

`endif

// ----- rtl/lrupr_pkg.sv -----
// Package for the LRU page replacement block: widths, defaults and state type.
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 8;

    localparam int PAGE_IN_W  = 8;
    localparam int PAGE_OUT_W = 8;
    localparam int SLOT_W     = 3;
    localparam int FC_W       = 4;
    localparam int AGE_W      = 8;
    localparam int FAULT_W    = 16;

    localparam logic [FC_W-1:0]    FC_RESET  = FC_W'(4);
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } t_state;

endpackage

// ----- rtl/lrupr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module lrupr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/lru_page_replacement.sv -----
// Top level of the LRU page replacement block with age counters held in RAM.
//
// Usage:
//   Command channel: drive i_page_id and raise start; the word is taken at a
//   clock edge where start is high and busy is low. busy stays high until
//   the result has been produced.
//   Result channel: o_done pulses for one cycle with o_hit, o_slot,
//   o_evicted_valid, o_evicted_page and o_fault_total. The receiver cannot
//   stall; fields hold their value until the next result.
//   Config channel: i_cfg_data (frame count) is written when i_cfg_valid and
//   o_cfg_ready are both high; o_cfg_ready is low while busy.
//   Sequencing: the frame RAM's single read port sets the pace over the n
//   active frames (1..MAX_FRAMES): one pass finds hit, empty slot and oldest
//   frame, a second read-modify-writes ages. busy drops together with o_done,
//   so the next word goes in on the edge that ends the result cycle; a word
//   is taken only once the last one is through.
//   Reset: all frames empty, fault total zero, frame count four; ages in RAM are not cleared.
//   No RAM clearing pass is needed, so the block is ready straight away.
module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lrupr_pkg::FC_W-1:0]       i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [lrupr_pkg::PAGE_IN_W-1:0]  i_page_id,
    output logic                             o_done,
    output logic                             o_hit,
    output logic [lrupr_pkg::SLOT_W-1:0]     o_slot,
    output logic                             o_evicted_valid,
    output logic [lrupr_pkg::PAGE_OUT_W-1:0] o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]    o_fault_total
);

    import lrupr_pkg::*;

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int K_W    = IDX_W + 1;
    localparam int WORD_W = AGE_W + PAGE_BITS;

    typedef struct packed {
        logic [AGE_W-1:0]     age;
        logic [PAGE_BITS-1:0] page;
    } t_entry;

    // control
    t_state                  r_state, n_state;
    logic [K_W-1:0]          r_k, n_k;
    logic                    r_pend, n_pend;
    logic [MAX_FRAMES-1:0]   r_valid, n_valid;
    logic [FAULT_W-1:0]      r_fault, n_fault;
    logic [FC_W-1:0]         r_frame_count, n_frame_count;
    logic                    r_done, n_done;
    logic                    r_o_hit, n_o_hit;
    logic [SLOT_W-1:0]       r_o_slot, n_o_slot;
    logic                    r_o_evv, n_o_evv;
    logic [PAGE_OUT_W-1:0]   r_o_evp, n_o_evp;
    logic [FAULT_W-1:0]      r_o_fault, n_o_fault;

    // per-item working registers
    logic [IDX_W-1:0]        r_pidx, n_pidx;
    logic [K_W-1:0]          r_n, n_n;
    logic [PAGE_BITS-1:0]    r_page, n_page;
    logic                    r_hit_found, n_hit_found;
    logic [IDX_W-1:0]        r_hit_idx, n_hit_idx;
    logic                    r_empty_found, n_empty_found;
    logic [IDX_W-1:0]        r_empty_idx, n_empty_idx;
    logic [AGE_W-1:0]        r_best_age, n_best_age;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [PAGE_BITS-1:0]    r_best_page, n_best_page;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic                    r_miss, n_miss;
    logic                    r_evict, n_evict;

    logic [K_W-1:0]          act_n;
    logic                    issue;
    logic                    ram_we;
    t_entry                  ram_wdata;
    logic [WORD_W-1:0]       ram_rdata;
    t_entry                  q;
    logic                    v_q;
    logic [31:0]             slot_ext;
    logic [31:0]             page_ext;

    // clamp the frame count into 1..MAX_FRAMES
    always_comb begin
        if (r_frame_count == '0) begin
            act_n = K_W'(1);
        end else if (32'(r_frame_count) > 32'(MAX_FRAMES)) begin
            act_n = K_W'(MAX_FRAMES);
        end else begin
            act_n = K_W'(r_frame_count);
        end
    end

    assign q        = t_entry'(ram_rdata);
    assign v_q      = r_valid[r_pidx];
    assign issue    = ((r_state == S_SCAN) || (r_state == S_UPD)) && (r_k < r_n);
    assign slot_ext = 32'(r_slot);
    assign page_ext = 32'(r_best_page);

    lrupr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_FRAMES)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pidx),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (r_k[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_k           = issue ? (r_k + K_W'(1)) : r_k;
        n_pend        = issue;
        n_pidx        = r_k[IDX_W-1:0];
        n_valid       = r_valid;
        n_fault       = r_fault;
        n_frame_count = r_frame_count;
        n_done        = 1'b0;
        n_o_hit       = r_o_hit;
        n_o_slot      = r_o_slot;
        n_o_evv       = r_o_evv;
        n_o_evp       = r_o_evp;
        n_o_fault     = r_o_fault;
        n_n           = r_n;
        n_page        = r_page;
        n_hit_found   = r_hit_found;
        n_hit_idx     = r_hit_idx;
        n_empty_found = r_empty_found;
        n_empty_idx   = r_empty_idx;
        n_best_age    = r_best_age;
        n_best_idx    = r_best_idx;
        n_best_page   = r_best_page;
        n_slot        = r_slot;
        n_miss        = r_miss;
        n_evict       = r_evict;
        ram_we        = 1'b0;
        ram_wdata     = q;

        if (i_cfg_valid && o_cfg_ready) begin
            n_frame_count = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state       = S_SCAN;
                    n_k           = '0;
                    n_n           = act_n;
                    n_page        = PAGE_BITS'(i_page_id);
                    n_hit_found   = 1'b0;
                    n_empty_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (!r_hit_found && v_q && (q.page == r_page)) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_pidx;
                    end
                    if (!r_empty_found && !v_q) begin
                        n_empty_found = 1'b1;
                        n_empty_idx   = r_pidx;
                    end
                    // strictly greater keeps the lowest index on a tie
                    if ((r_pidx == '0) || (q.age > r_best_age)) begin
                        n_best_age  = q.age;
                        n_best_idx  = r_pidx;
                        n_best_page = q.page;
                    end
                end
                if (!issue && !r_pend) begin
                    n_state = S_UPD;
                    n_k     = '0;
                    if (r_hit_found) begin
                        n_slot  = r_hit_idx;
                        n_miss  = 1'b0;
                        n_evict = 1'b0;
                    end else begin
                        n_slot  = r_empty_found ? r_empty_idx : r_best_idx;
                        n_miss  = 1'b1;
                        n_evict = !r_empty_found;
                        n_valid[n_slot] = 1'b1;
                        if (r_fault != FAULT_MAX) begin
                            n_fault = r_fault + FAULT_W'(1);
                        end
                    end
                end
            end
            S_UPD: begin
                // write back the word read last cycle; addresses never collide
                if (r_pend) begin
                    if (r_pidx == r_slot) begin
                        ram_we         = 1'b1;
                        ram_wdata.age  = '0;
                        ram_wdata.page = r_page;
                    end else if (v_q) begin
                        ram_we = 1'b1;
                        if (q.age != AGE_MAX) begin
                            ram_wdata.age = q.age + AGE_W'(1);
                        end
                    end
                end
                if (!issue && !r_pend) begin
                    n_state   = S_IDLE;
                    n_done    = 1'b1;
                    n_o_hit   = !r_miss;
                    n_o_slot  = slot_ext[SLOT_W-1:0];
                    n_o_evv   = r_evict;
                    n_o_evp   = r_evict ? page_ext[PAGE_OUT_W-1:0] : '0;
                    n_o_fault = r_fault;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= '0;
            r_pend        <= 1'b0;
            r_valid       <= '0;
            r_fault       <= '0;
            r_frame_count <= FC_RESET;
            r_done        <= 1'b0;
            r_o_hit       <= 1'b0;
            r_o_slot      <= '0;
            r_o_evv       <= 1'b0;
            r_o_evp       <= '0;
            r_o_fault     <= '0;
        end else begin
            r_state       <= n_state;
            r_k           <= n_k;
            r_pend        <= n_pend;
            r_valid       <= n_valid;
            r_fault       <= n_fault;
            r_frame_count <= n_frame_count;
            r_done        <= n_done;
            r_o_hit       <= n_o_hit;
            r_o_slot      <= n_o_slot;
            r_o_evv       <= n_o_evv;
            r_o_evp       <= n_o_evp;
            r_o_fault     <= n_o_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx        <= n_pidx;
        r_n           <= n_n;
        r_page        <= n_page;
        r_hit_found   <= n_hit_found;
        r_hit_idx     <= n_hit_idx;
        r_empty_found <= n_empty_found;
        r_empty_idx   <= n_empty_idx;
        r_best_age    <= n_best_age;
        r_best_idx    <= n_best_idx;
        r_best_page   <= n_best_page;
        r_slot        <= n_slot;
        r_miss        <= n_miss;
        r_evict       <= n_evict;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_done          = r_done;
    assign o_hit           = r_o_hit;
    assign o_slot          = r_o_slot;
    assign o_evicted_valid = r_o_evv;
    assign o_evicted_page  = r_o_evp;
    assign o_fault_total   = r_o_fault;

endmodule

// ----- rtl/lrupr_checker.sv -----
// Port-level checker for the LRU page replacement block, bound to the top level.
`include "lru_page_replacement_macros.svh"

module lrupr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          i_busy,
    input logic                          i_done,
    input logic                          i_hit,
    input logic                          i_evicted_valid,
    input logic [lrupr_pkg::FAULT_W-1:0] i_fault_total
);

    import lrupr_pkg::*;

    `LRUPR_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    `LRUPR_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, i_done, !i_done)
    `LRUPR_ASSERT(a_evict_on_miss, i_clk, i_rst_n, i_done && i_evicted_valid, !i_hit)
    `LRUPR_ASSERT(a_hit_no_fault, i_clk, i_rst_n, i_done && i_hit, i_fault_total == $past(i_fault_total))
    `LRUPR_ASSERT(a_miss_count, i_clk, i_rst_n, i_done && !i_hit && ($past(i_fault_total) != FAULT_MAX), i_fault_total == FAULT_W'($past(i_fault_total) + FAULT_W'(1)))

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_done          (o_done),
    .i_hit           (o_hit),
    .i_evicted_valid (o_evicted_valid),
    .i_fault_total   (o_fault_total)
);

// ----- tb/lru_page_replacement_tb.sv -----
// Self-checking testbench for the LRU page replacement block with age counters.
module lru_page_replacement_tb;
    import lrupr_pkg::*;

    localparam int NFRAMES     = MAX_FRAMES_DEF;
    localparam int RANDOM_REFS = 1110;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * NFRAMES + 8;
    localparam int MAX_REPORTS = 10;
    localparam int N_STEER     = 25;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic                  evicted_valid;
        logic [PAGE_OUT_W-1:0] evicted_page;
        logic [FAULT_W-1:0]    fault_total;
    } t_lookup;

    typedef enum logic {ROW_PAGE, ROW_CFG} t_row_kind;
    typedef enum int {MIX_POOL, MIX_NOISE, MIX_HOT} t_mix;

    typedef struct packed {
        t_row_kind            kind;
        logic [PAGE_IN_W-1:0] value;
        logic                 typed;
        t_lookup              want;
    } t_steer_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [FC_W-1:0]       i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [PAGE_IN_W-1:0]  i_page_id;
    logic                  o_done;
    logic                  o_hit;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_evicted_valid;
    logic [PAGE_OUT_W-1:0] o_evicted_page;
    logic [FAULT_W-1:0]    o_fault_total;

    // Frame state as the block should hold it
    logic [PAGE_IN_W-1:0] held_page  [NFRAMES];
    logic                 held_valid [NFRAMES];
    logic [AGE_W-1:0]     held_age   [NFRAMES];
    logic [FAULT_W-1:0]   miss_total;
    logic [FC_W-1:0]      frames_reg;

    t_lookup lookup_q [$];
    int      mismatch_count;
    int      stall_cycles;
    int      n_hits;
    int      n_misses;
    int      n_cfg_writes;
    int      oldest_age;

    logic [FC_W-1:0] fc_corners [4] = '{4'd0, 4'd1, 4'd8, 4'd15};

    // Typed-in rows follow from reset at four frames; the rest go to the predictor.
    t_steer_row steer_rows [N_STEER] = '{
        {ROW_PAGE, 8'h00, 1'b1, {1'b0, 3'd0, 1'b0, 8'h00, 16'd1}},
        {ROW_PAGE, 8'hFF, 1'b1, {1'b0, 3'd1, 1'b0, 8'h00, 16'd2}},
        {ROW_PAGE, 8'h00, 1'b1, {1'b1, 3'd0, 1'b0, 8'h00, 16'd2}},
        {ROW_PAGE, 8'h80, 1'b1, {1'b0, 3'd2, 1'b0, 8'h00, 16'd3}},
        {ROW_PAGE, 8'h01, 1'b1, {1'b0, 3'd3, 1'b0, 8'h00, 16'd4}},
        {ROW_PAGE, 8'h7F, 1'b1, {1'b0, 3'd1, 1'b1, 8'hFF, 16'd5}},
        {ROW_PAGE, 8'h7F, 1'b0, 29'd0},
        {ROW_PAGE, 8'h01, 1'b0, 29'd0},
        {ROW_CFG,  8'd1,  1'b0, 29'd0},
        {ROW_PAGE, 8'h55, 1'b0, 29'd0},
        {ROW_PAGE, 8'h55, 1'b0, 29'd0},
        {ROW_CFG,  8'd0,  1'b0, 29'd0},
        {ROW_PAGE, 8'hAA, 1'b0, 29'd0},
        {ROW_CFG,  8'd15, 1'b0, 29'd0},
        {ROW_PAGE, 8'h10, 1'b0, 29'd0},
        {ROW_PAGE, 8'h7F, 1'b0, 29'd0},
        {ROW_PAGE, 8'h20, 1'b0, 29'd0},
        {ROW_PAGE, 8'h40, 1'b0, 29'd0},
        {ROW_PAGE, 8'h08, 1'b0, 29'd0},
        {ROW_PAGE, 8'hF0, 1'b0, 29'd0},
        {ROW_CFG,  8'd8,  1'b0, 29'd0},
        {ROW_PAGE, 8'h80, 1'b0, 29'd0},
        {ROW_CFG,  8'd4,  1'b0, 29'd0},
        {ROW_PAGE, 8'h02, 1'b0, 29'd0},
        {ROW_PAGE, 8'h7F, 1'b0, 29'd0}
    };

    lru_page_replacement u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_page_id       (i_page_id),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_lookup lru_lookup(input logic [PAGE_IN_W-1:0] page);
        t_lookup r;
        int      n;
        int      k;
        int      slot;
        bit      found;
        bit      empty;
        n = (frames_reg == 0) ? 1 : ((frames_reg > NFRAMES) ? NFRAMES : int'(frames_reg));
        r = '0;
        slot = 0;
        found = 1'b0;
        empty = 1'b0;
        for (k = 0; k < n; k++)
            if (!found && held_valid[k] && held_page[k] == page) begin
                found = 1'b1;
                slot = k;
            end
        if (found) begin
            n_hits++;
        end else begin
            for (k = 0; k < n; k++)
                if (!found && !empty && !held_valid[k]) begin
                    empty = 1'b1;
                    slot = k;
                end
            if (!empty) begin
                // oldest frame goes, lowest index wins a tie
                slot = 0;
                for (k = 1; k < n; k++)
                    if (held_age[k] > held_age[slot])
                        slot = k;
                r.evicted_valid = 1'b1;
                r.evicted_page  = held_page[slot];
            end
            held_page[slot]  = page;
            held_valid[slot] = 1'b1;
            if (miss_total != FAULT_MAX)
                miss_total++;
            n_misses++;
        end
        // frames beyond the count and empty frames keep their age
        for (k = 0; k < n; k++) begin
            if (k == slot)
                held_age[k] = '0;
            else if (held_valid[k] && held_age[k] != AGE_MAX)
                held_age[k]++;
            if (held_age[k] > oldest_age)
                oldest_age = held_age[k];
        end
        r.hit         = found;
        r.slot        = SLOT_W'(slot);
        r.fault_total = miss_total;
        return r;
    endfunction

    function automatic string show_lookup(input t_lookup v);
        return $sformatf("hit=%0d slot=%0d evicted=%0d page=%02h faults=%0d",
                         v.hit, v.slot, v.evicted_valid, v.evicted_page, v.fault_total);
    endfunction

    task automatic note_mismatch(input string what, input t_lookup want, input t_lookup got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("lookup mismatch (%s) at %0t", what, $time);
            $display("  expected %s", show_lookup(want));
            $display("  got      %s", show_lookup(got));
        end
    endtask

    // start stays high when the next word follows straight on
    task automatic send_page(input logic [PAGE_IN_W-1:0] page, input int gap,
                             input bit typed, input t_lookup want);
        t_lookup predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_page_id <= page;
        do @(posedge i_clk); while (busy);
        predicted = lru_lookup(page);
        lookup_q.push_back(typed ? want : predicted);
    endtask

    // checked on the falling edge so the monitor's pop has settled
    task automatic drain_lookups();
        start <= 1'b0;
        do @(negedge i_clk); while (lookup_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_frames(input logic [FC_W-1:0] value);
        drain_lookups();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        frames_reg = value;
        n_cfg_writes++;
    endtask

    always @(posedge i_clk) begin
        t_lookup seen;
        t_lookup wanted;
        string   fields;
        seen = {o_hit, o_slot, o_evicted_valid, o_evicted_page, o_fault_total};
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (o_done) begin
                if (lookup_q.size() == 0) begin
                    note_mismatch("no lookup pending", '0, seen);
                end else begin
                    wanted = lookup_q.pop_front();
                    fields = "";
                    if (seen.hit !== wanted.hit)
                        fields = {fields, " hit"};
                    if (seen.slot !== wanted.slot)
                        fields = {fields, " slot"};
                    if (seen.evicted_valid !== wanted.evicted_valid)
                        fields = {fields, " evicted_valid"};
                    if (seen.evicted_page !== wanted.evicted_page)
                        fields = {fields, " evicted_page"};
                    if (seen.fault_total !== wanted.fault_total)
                        fields = {fields, " fault_total"};
                    if (fields != "")
                        note_mismatch({"field", fields}, wanted, seen);
                end
            end
            if (o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        int                   phase;
        int                   len;
        int                   pool_size;
        int                   random_refs;
        int                   pick;
        bit                   idle_on;
        t_mix                 mix;
        logic [PAGE_IN_W-1:0] page;
        logic [FC_W-1:0]      fc_next;
        logic [PAGE_IN_W-1:0] pool [$];

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        start       = 1'b0;
        i_page_id   = '0;
        for (int k = 0; k < NFRAMES; k++) begin
            held_page[k]  = '0;
            held_valid[k] = 1'b0;
            held_age[k]   = '0;
        end
        miss_total     = '0;
        frames_reg     = FC_RESET;
        mismatch_count = 0;
        stall_cycles   = 0;
        n_hits         = 0;
        n_misses       = 0;
        n_cfg_writes   = 0;
        oldest_age     = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_STEER; r++) begin
            if (steer_rows[r].kind == ROW_CFG)
                write_frames(steer_rows[r].value[FC_W-1:0]);
            else
                send_page(steer_rows[r].value, $urandom_range(0, 16),
                          steer_rows[r].typed, steer_rows[r].want);
        end

        random_refs = 0;
        phase = 0;
        while (random_refs < RANDOM_REFS) begin
            pick = $urandom_range(0, 19);
            if (phase == 2 || pick == 0)
                mix = MIX_HOT;
            else if (pick < 15)
                mix = MIX_POOL;
            else
                mix = MIX_NOISE;

            if (mix == MIX_HOT)
                fc_next = $urandom_range(0, 1) ? 4'd8 : 4'd15;
            else if ($urandom_range(0, 3) == 0)
                fc_next = fc_corners[$urandom_range(0, 3)];
            else
                fc_next = FC_W'($urandom_range(0, 15));
            write_frames(fc_next);

            // hot phase: fill all frames, hammer one page until the rest saturate,
            // then miss so that eviction has to break ties between saturated ages
            len       = (mix == MIX_HOT) ? 280 : $urandom_range(20, 60);
            if (len > RANDOM_REFS - random_refs)
                len = RANDOM_REFS - random_refs;
            pool_size = (mix == MIX_HOT) ? NFRAMES : $urandom_range(1, 18);
            idle_on   = ($urandom_range(0, 2) != 0);
            pool.delete();
            for (int k = 0; k < pool_size; k++)
                pool.push_back(PAGE_IN_W'($urandom));

            for (int i = 0; i < len; i++) begin
                case (mix)
                    MIX_POOL:
                        page = ($urandom_range(0, 9) == 0) ? PAGE_IN_W'($urandom)
                                                          : pool[$urandom_range(0, pool_size - 1)];
                    MIX_HOT:
                        page = (i < NFRAMES) ? pool[i]
                             : (i < len - 10) ? pool[0] : PAGE_IN_W'($urandom);
                    default:
                        page = PAGE_IN_W'($urandom);
                endcase
                send_page(page, idle_on ? $urandom_range(0, 16) : 0, 1'b0, '0);
                random_refs++;
            end
            phase++;
        end

        // single frame: nearly every word is a miss and evicts the last page
        write_frames(4'd1);
        for (int i = 0; i < 20; i++)
            send_page(PAGE_IN_W'($urandom), $urandom_range(0, 16), 1'b0, '0);

        drain_lookups();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d references (%0d hits, %0d faults) over %0d frame-count writes",
                 n_hits + n_misses, n_hits, n_misses, n_cfg_writes);
        $display("Fault total ended at %0d, oldest frame age reached %0d; %0d mismatches",
                 miss_total, oldest_age, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
